/* rtl/tbam_pkg.sv */
// ----------------------------------------------------------------------------
// tbam_pkg
// Shared types, widths and codes for the track/box association memory.
// ----------------------------------------------------------------------------
package tbam_pkg;

  // geometry and storage sizes
  localparam int COORD_BITS       = 12;
  localparam int TARGET_DEPTH     = 3;
  localparam int DISTRACTOR_DEPTH = 6;
  localparam int AREA_DEPTH       = 10;

  localparam int THR_W     = 9;
  localparam int AREA_W    = 2 * COORD_BITS;
  localparam int UNION_W   = AREA_W + 1;
  localparam int PROD_W    = UNION_W + THR_W;
  localparam int BOX_W     = 4 * COORD_BITS;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 4;
  localparam int CFG_IDX_W = 2;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((BOX_W + 1 + 7) / 8) * 8;
  localparam int M_TDATA_W = ((BOX_W + 3 + 7) / 8) * 8;

  // ring pointers and fill counts
  localparam int T_IW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam int D_IW = (DISTRACTOR_DEPTH > 1) ? $clog2(DISTRACTOR_DEPTH) : 1;
  localparam int A_IW = (AREA_DEPTH > 1) ? $clog2(AREA_DEPTH) : 1;
  localparam int T_CW = $clog2(TARGET_DEPTH + 1);
  localparam int D_CW = $clog2(DISTRACTOR_DEPTH + 1);
  localparam int A_CW = $clog2(AREA_DEPTH + 1);

  // box with x in the lowest bits
  typedef struct packed {
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } box_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_SELECT, REQ_DETECT, REQ_END, REQ_REPORT
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED, ST_PENDING, ST_EMPTY, ST_STARTED, ST_NO_MATCH, ST_REACQUIRED,
    ST_DISTRACTOR, ST_RECOVERED, ST_OCCLUDED, ST_LOST, ST_UPDATED
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELECT_IOU, CFG_ACCEPT_IOU, CFG_DISTRACT_IOU, CFG_AREA_TOL
  } cfg_e;

  typedef enum logic [3:0] {
    TB_IDLE, TB_GEOM, TB_UNION, TB_MATCH, TB_BELOW, TB_MEDIAN, TB_SPREAD,
    TB_DIFF, TB_AREA, TB_RECOVER, TB_OUT
  } fsm_e;

endpackage

/* rtl/tbam_ram.sv */
// ----------------------------------------------------------------------------
// tbam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/track_box_association_memory.sv */
// ----------------------------------------------------------------------------
// track_box_association_memory
// Target/distractor association for a box tracker: IoU gating, target and
// distractor rings in RAM, area history with median check, recovery.
// ----------------------------------------------------------------------------
// Path: selection, report, end mark and ignored items go straight to output;
//   recovery passes TB_RECOVER; detection passes TB_GEOM to TB_MATCH, and a
//   tracking miss TB_BELOW, then with stored areas TB_MEDIAN to TB_AREA.
// Throughput: one item at a time; the median pass over the area history
//   handles one stored area per cycle and is the longest path.
// Reset: flags, roi, counts and thresholds clear to their defaults at once;
//   ring contents are undefined and only ever read below their counts.
module track_box_association_memory
  import tbam_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  // requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_x, box_y, box_w, box_h, tracker_ok, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [REQ_W-1:0]     s_axis_tuser,
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // roi_x, roi_y, roi_w, roi_h, reinit_tracker, tracking, occluded, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]  m_axis_tuser
);

  // control state
  fsm_e              state_q, state_d;
  logic              trk_q, trk_d, occl_q, occl_d, pend_q, pend_d, found_q, found_d;
  box_t              roi_q, roi_d;
  logic [T_CW-1:0]   tcnt_q, tcnt_d;
  logic [T_IW-1:0]   twp_q, twp_d;
  logic [D_CW-1:0]   dcnt_q, dcnt_d;
  logic [D_IW-1:0]   dwp_q, dwp_d;
  logic [A_CW-1:0]   acnt_q, acnt_d;
  logic [A_IW-1:0]   mj_q, mj_d;
  logic [THR_W-1:0]  sel_thr_q, acc_thr_q, dis_thr_q, tol_q;
  logic              out_valid_q, out_valid_d;
  status_e           res_status_q, res_status_d, out_status_q, out_status_d;
  logic              res_reinit_q, res_reinit_d;
  logic [BOX_W+2:0]  out_data_q, out_data_d;

  // payload
  box_t              box_q, box_d;
  logic [AREA_W-1:0] area_q [AREA_DEPTH];
  logic [AREA_W-1:0] area_d [AREA_DEPTH];
  logic [AREA_W-1:0] inter_q, inter_d, area_a_q, area_a_d, area_b_q, area_b_d;
  logic [AREA_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [UNION_W-1:0] uni_q, uni_d, m2_q, m2_d, dif_q, dif_d;
  logic              below_q, below_d;

  // ram ports
  logic              t_we, d_we;
  box_t              t_rdata, d_rdata;
  logic [T_IW-1:0]   t_newest;
  logic [D_IW-1:0]   d_newest;

  // geometry and shared multiplier
  logic [COORD_BITS:0]   ax2, bx2, ay2, by2, x2, y2;
  logic [COORD_BITS-1:0] x1, y1, iw, ih;
  logic [THR_W-1:0]      mul_thr;
  logic [UNION_W-1:0]    mul_op;
  logic [PROD_W-1:0]     prod, lhs;
  logic [AREA_W-1:0]     cand;
  logic [A_CW-1:0]       rank, half;
  logic [UNION_W-1:0]    a2;
  box_t                  s_box, rec_box;
  req_e                  s_req;

  assign s_box    = s_axis_tdata[BOX_W-1:0];
  assign s_req    = req_e'(s_axis_tuser);
  assign t_newest = (twp_q == '0) ? T_IW'(TARGET_DEPTH - 1) : twp_q - 1'b1;
  assign d_newest = (dwp_q == '0) ? D_IW'(DISTRACTOR_DEPTH - 1) : dwp_q - 1'b1;

  tbam_ram #(.WIDTH(BOX_W), .DEPTH(TARGET_DEPTH)) u_target_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (twp_q),
    .wdata_i (box_q),
    .raddr_i (t_newest),
    .rdata_o (t_rdata)
  );

  tbam_ram #(.WIDTH(BOX_W), .DEPTH(DISTRACTOR_DEPTH)) u_distract_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (dwp_q),
    .wdata_i (box_q),
    .raddr_i (d_newest),
    .rdata_o (d_rdata)
  );

  // intersection extents of roi and the held box
  always_comb begin
    x1  = (roi_q.x > box_q.x) ? roi_q.x : box_q.x;
    y1  = (roi_q.y > box_q.y) ? roi_q.y : box_q.y;
    ax2 = {1'b0, roi_q.x} + {1'b0, roi_q.w};
    bx2 = {1'b0, box_q.x} + {1'b0, box_q.w};
    ay2 = {1'b0, roi_q.y} + {1'b0, roi_q.h};
    by2 = {1'b0, box_q.y} + {1'b0, box_q.h};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    iw  = (x2 > {1'b0, x1}) ? COORD_BITS'(x2 - {1'b0, x1}) : '0;
    ih  = (y2 > {1'b0, y1}) ? COORD_BITS'(y2 - {1'b0, y1}) : '0;
  end

  // one threshold multiplier shared by all ratio tests
  always_comb begin
    case (state_q)
      TB_MATCH: mul_thr = pend_q ? sel_thr_q : acc_thr_q;
      TB_BELOW: mul_thr = dis_thr_q;
      default:  mul_thr = tol_q;
    endcase
    mul_op = (state_q == TB_AREA) ? m2_q : uni_q;
    prod   = PROD_W'(mul_thr) * PROD_W'(mul_op);
    lhs    = PROD_W'({inter_q, 8'b0});
  end

  // stable rank of one stored area among the valid ones
  always_comb begin
    cand = area_q[mj_q];
    rank = '0;
    for (int i = 0; i < AREA_DEPTH; i++) begin
      if ((A_CW'(i) < acnt_q) &&
          ((area_q[i] < cand) || ((area_q[i] == cand) && (A_IW'(i) < mj_q)))) begin
        rank = rank + 1'b1;
      end
    end
    half = acnt_q >> 1;
    a2   = {area_b_q, 1'b0};
  end

  assign rec_box = (dcnt_q != '0) ? d_rdata : t_rdata;

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    trk_d        = trk_q;
    occl_d       = occl_q;
    pend_d       = pend_q;
    found_d      = found_q;
    roi_d        = roi_q;
    tcnt_d       = tcnt_q;
    twp_d        = twp_q;
    dcnt_d       = dcnt_q;
    dwp_d        = dwp_q;
    acnt_d       = acnt_q;
    mj_d         = mj_q;
    res_status_d = res_status_q;
    res_reinit_d = res_reinit_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    box_d        = box_q;
    area_d       = area_q;
    inter_d      = inter_q;
    area_a_d     = area_a_q;
    area_b_d     = area_b_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    m2_d         = m2_q;
    dif_d        = dif_q;
    uni_d        = uni_q;
    below_d      = below_q;
    t_we         = 1'b0;
    d_we         = 1'b0;
    s_axis_tready = (state_q == TB_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      TB_IDLE: begin
        if (s_axis_tvalid) begin
          box_d        = s_box;
          res_status_d = ST_IGNORED;
          res_reinit_d = 1'b0;
          state_d      = TB_OUT;
          case (s_req)
            REQ_SELECT: begin
              roi_d = s_box;
              if (s_box.w == '0 || s_box.h == '0) begin
                pend_d       = 1'b0;
                res_status_d = ST_EMPTY;
              end else begin
                pend_d       = 1'b1;
                res_status_d = ST_PENDING;
              end
            end
            REQ_DETECT: begin
              if (!found_q && (pend_q || trk_q)) begin
                state_d = TB_GEOM;
              end
            end
            REQ_END: begin
              found_d = 1'b0;
              if (pend_q) begin
                pend_d       = 1'b0;
                res_status_d = ST_NO_MATCH;
              end else if (trk_q) begin
                if (found_q) begin
                  occl_d       = 1'b0;
                  res_status_d = ST_REACQUIRED;
                end else if (dcnt_q != '0 || tcnt_q != '0) begin
                  state_d = TB_RECOVER;
                end else begin
                  occl_d       = 1'b1;
                  res_status_d = ST_OCCLUDED;
                end
              end
            end
            default: begin
              if (trk_q) begin
                if (s_axis_tdata[BOX_W]) begin
                  roi_d        = s_box;
                  res_status_d = ST_UPDATED;
                end else begin
                  trk_d        = 1'b0;
                  occl_d       = 1'b1;
                  res_status_d = ST_LOST;
                end
              end
            end
          endcase
        end
      end

      // areas of roi, box and their overlap
      TB_GEOM: begin
        inter_d  = AREA_W'(iw) * AREA_W'(ih);
        area_a_d = AREA_W'(roi_q.w) * AREA_W'(roi_q.h);
        area_b_d = AREA_W'(box_q.w) * AREA_W'(box_q.h);
        state_d  = TB_UNION;
      end

      TB_UNION: begin
        uni_d   = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
        state_d = TB_MATCH;
      end

      // iou above the select or accept threshold
      TB_MATCH: begin
        if (inter_q != '0 && lhs > prod) begin
          roi_d        = box_q;
          t_we         = 1'b1;
          twp_d        = (twp_q == T_IW'(TARGET_DEPTH - 1)) ? '0 : twp_q + 1'b1;
          if (tcnt_q != T_CW'(TARGET_DEPTH)) begin
            tcnt_d = tcnt_q + 1'b1;
          end
          if (acnt_q == A_CW'(AREA_DEPTH)) begin
            for (int i = 0; i < AREA_DEPTH - 1; i++) begin
              area_d[i] = area_q[i + 1];
            end
            area_d[AREA_DEPTH-1] = area_b_q;
          end else begin
            area_d[acnt_q[A_IW-1:0]] = area_b_q;
            acnt_d = acnt_q + 1'b1;
          end
          found_d      = 1'b1;
          res_reinit_d = 1'b1;
          if (pend_q) begin
            trk_d        = 1'b1;
            occl_d       = 1'b0;
            pend_d       = 1'b0;
            res_status_d = ST_STARTED;
          end else begin
            res_status_d = ST_REACQUIRED;
          end
          state_d = TB_OUT;
        end else if (pend_q) begin
          res_status_d = ST_PENDING;
          state_d      = TB_OUT;
        end else begin
          state_d = TB_BELOW;
        end
      end

      // iou below the distractor threshold
      TB_BELOW: begin
        below_d = (inter_q == '0) ? (dis_thr_q != '0) : (lhs < prod);
        mj_d    = '0;
        if (acnt_q == '0) begin
          res_status_d = ST_NO_MATCH;
          state_d      = TB_OUT;
        end else begin
          state_d = TB_MEDIAN;
        end
      end

      // median by rank, one stored area per cycle
      TB_MEDIAN: begin
        if (rank == half) begin
          hi_d = cand;
        end
        if (!acnt_q[0] && (rank == half - 1'b1)) begin
          lo_d = cand;
        end
        mj_d = mj_q + 1'b1;
        if (A_CW'(mj_q) == acnt_q - 1'b1) begin
          state_d = TB_SPREAD;
        end
      end

      TB_SPREAD: begin
        m2_d    = acnt_q[0] ? {hi_q, 1'b0} : ({1'b0, lo_q} + {1'b0, hi_q});
        state_d = TB_DIFF;
      end

      TB_DIFF: begin
        dif_d   = (a2 > m2_q) ? (a2 - m2_q) : (m2_q - a2);
        state_d = TB_AREA;
      end

      // area tolerance against the median
      TB_AREA: begin
        if (m2_q != '0 && below_q && (PROD_W'({dif_q, 8'b0}) <= prod)) begin
          d_we         = 1'b1;
          dwp_d        = (dwp_q == D_IW'(DISTRACTOR_DEPTH - 1)) ? '0 : dwp_q + 1'b1;
          if (dcnt_q != D_CW'(DISTRACTOR_DEPTH)) begin
            dcnt_d = dcnt_q + 1'b1;
          end
          res_status_d = ST_DISTRACTOR;
        end else begin
          res_status_d = ST_NO_MATCH;
        end
        state_d = TB_OUT;
      end

      // newest distractor or target, from the registered ram read
      TB_RECOVER: begin
        if (rec_box.w != '0 && rec_box.h != '0) begin
          roi_d        = rec_box;
          occl_d       = 1'b0;
          res_reinit_d = 1'b1;
          res_status_d = ST_RECOVERED;
        end else begin
          occl_d       = 1'b1;
          res_status_d = ST_OCCLUDED;
        end
        state_d = TB_OUT;
      end

      TB_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = {occl_q, trk_q, res_reinit_q, roi_q};
          state_d      = TB_IDLE;
        end
      end

      default: begin
        state_d = TB_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TB_IDLE;
      trk_q        <= 1'b0;
      occl_q       <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      roi_q        <= '0;
      tcnt_q       <= '0;
      twp_q        <= '0;
      dcnt_q       <= '0;
      dwp_q        <= '0;
      acnt_q       <= '0;
      mj_q         <= '0;
      res_status_q <= ST_IGNORED;
      res_reinit_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_IGNORED;
    end else begin
      state_q      <= state_d;
      trk_q        <= trk_d;
      occl_q       <= occl_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      roi_q        <= roi_d;
      tcnt_q       <= tcnt_d;
      twp_q        <= twp_d;
      dcnt_q       <= dcnt_d;
      dwp_q        <= dwp_d;
      acnt_q       <= acnt_d;
      mj_q         <= mj_d;
      res_status_q <= res_status_d;
      res_reinit_q <= res_reinit_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_thr_q <= THR_W'(102);
      acc_thr_q <= THR_W'(102);
      dis_thr_q <= THR_W'(102);
      tol_q     <= THR_W'(230);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_SELECT_IOU:   sel_thr_q <= cfg_data_i;
        CFG_ACCEPT_IOU:   acc_thr_q <= cfg_data_i;
        CFG_DISTRACT_IOU: dis_thr_q <= cfg_data_i;
        default:          tol_q     <= cfg_data_i;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    box_q      <= box_d;
    area_q     <= area_d;
    inter_q    <= inter_d;
    area_a_q   <= area_a_d;
    area_b_q   <= area_b_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    m2_q       <= m2_d;
    dif_q      <= dif_d;
    uni_q      <= uni_d;
    below_q    <= below_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = M_TDATA_W'(out_data_q);

  // checks
  a_cnt_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tcnt_q <= T_CW'(TARGET_DEPTH)) && (dcnt_q <= D_CW'(DISTRACTOR_DEPTH)) &&
    (acnt_q <= A_CW'(AREA_DEPTH)))
    else $error("ring count beyond depth");

  a_start_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_STARTED) |-> (out_data_q[BOX_W] &&
      out_data_q[BOX_W+1] && !out_data_q[BOX_W+2]))
    else $error("start result without reinit and tracking");

  a_lost_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_LOST) |-> (!out_data_q[BOX_W+1] &&
      out_data_q[BOX_W+2]))
    else $error("lost result still tracking");

  a_target_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_we |=> (acnt_q != '0) && (tcnt_q != '0))
    else $error("target push without area entry");

endmodule

/* bench/tb_track_box_association_memory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_box_association_memory
// Drives selections, detections, end marks and tracker reports with random
// handshake gaps and checks each result against a behavioral predictor of
// the target/distractor association logic.
// ----------------------------------------------------------------------------
module tb_track_box_association_memory;
  import tbam_pkg::*;

  localparam int LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [THR_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // box_x, box_y, box_w, box_h, tracker_ok, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // req_type
  logic [REQ_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // roi_x, roi_y, roi_w, roi_h, reinit_tracker, tracking, occluded, zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [STATUS_W-1:0]  m_axis_tuser;

  typedef struct packed {
    status_e status;
    box_t    roi;
    logic    reinit;
    logic    trk;
    logic    occ;
  } result_t;

  track_box_association_memory DUT (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [THR_W-1:0] thr_select, thr_accept, thr_distract, area_tol;
  logic  tracking_on, occluded_flag, sel_pending, found_now;
  box_t  roi;
  box_t  target_q[$];
  box_t  distract_q[$];
  longint area_q[$];

  result_t expected_q[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      quiet = 1'b0;
  int      rx_stall = 0;

  function automatic longint area_of(box_t b);
    return longint'(b.w) * longint'(b.h);
  endfunction

  function automatic longint overlap(box_t a, box_t b);
    longint x1, y1, x2, y2, ax2, bx2, ay2, by2;
    x1  = (a.x > b.x) ? a.x : b.x;
    y1  = (a.y > b.y) ? a.y : b.y;
    ax2 = longint'(a.x) + a.w;
    bx2 = longint'(b.x) + b.w;
    ay2 = longint'(a.y) + a.h;
    by2 = longint'(b.y) + b.h;
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    if (x2 <= x1 || y2 <= y1) return 0;
    return (x2 - x1) * (y2 - y1);
  endfunction

  function automatic bit iou_gt(box_t a, box_t b, longint t);
    longint i;
    i = overlap(a, b);
    if (i == 0) return 1'b0;
    return i * 256 > t * (area_of(a) + area_of(b) - i);
  endfunction

  function automatic bit iou_lt(box_t a, box_t b, longint t);
    longint i;
    i = overlap(a, b);
    if (i == 0) return t > 0;
    return i * 256 < t * (area_of(a) + area_of(b) - i);
  endfunction

  function automatic longint median_twice();
    longint s[$];
    int n;
    s = area_q;
    s.sort();
    n = s.size();
    if (n == 0) return 0;
    if (n % 2 == 0) return s[n/2-1] + s[n/2];
    return 2 * s[n/2];
  endfunction

  function automatic void store_target(box_t b);
    if (target_q.size() >= TARGET_DEPTH) target_q.delete(0);
    target_q.insert(target_q.size(), b);
    if (area_q.size() >= AREA_DEPTH) area_q.delete(0);
    area_q.insert(area_q.size(), area_of(b));
  endfunction

  task automatic predictor_reset();
    thr_select = 102; thr_accept = 102; thr_distract = 102; area_tol = 230;
    tracking_on = 0; occluded_flag = 0; sel_pending = 0; found_now = 0;
    roi = '0;
    target_q.delete(); distract_q.delete(); area_q.delete();
  endtask

  // work out the result of one request
  function automatic result_t predict_association(req_e req, box_t b, logic ok);
    result_t r;
    longint m2, a2, d;
    box_t m;
    r = '0;
    r.status = ST_IGNORED;
    case (req)
      REQ_SELECT: begin
        roi = b;
        if (b.w == 0 || b.h == 0) begin
          sel_pending = 0; r.status = ST_EMPTY;
        end else begin
          sel_pending = 1; r.status = ST_PENDING;
        end
      end
      REQ_DETECT: begin
        if (found_now) begin
          r.status = ST_IGNORED;
        end else if (sel_pending) begin
          if (iou_gt(roi, b, thr_select)) begin
            roi = b; store_target(b);
            tracking_on = 1; occluded_flag = 0; sel_pending = 0; found_now = 1;
            r.reinit = 1; r.status = ST_STARTED;
          end else r.status = ST_PENDING;
        end else if (tracking_on) begin
          if (iou_gt(roi, b, thr_accept)) begin
            roi = b; store_target(b); found_now = 1;
            r.reinit = 1; r.status = ST_REACQUIRED;
          end else begin
            m2 = median_twice();
            a2 = 2 * area_of(b);
            d = (a2 > m2) ? a2 - m2 : m2 - a2;
            if (m2 != 0 && iou_lt(roi, b, thr_distract) && d * 256 <= area_tol * m2) begin
              if (distract_q.size() >= DISTRACTOR_DEPTH) distract_q.delete(0);
              distract_q.insert(distract_q.size(), b);
              r.status = ST_DISTRACTOR;
            end else r.status = ST_NO_MATCH;
          end
        end
      end
      REQ_END: begin
        if (sel_pending) begin
          sel_pending = 0; r.status = ST_NO_MATCH;
        end else if (tracking_on) begin
          if (found_now) begin
            occluded_flag = 0; r.status = ST_REACQUIRED;
          end else begin
            m = '0;
            if (distract_q.size() > 0) m = distract_q[$];
            else if (target_q.size() > 0) m = target_q[$];
            if (area_of(m) > 0) begin
              roi = m; occluded_flag = 0; r.reinit = 1; r.status = ST_RECOVERED;
            end else begin
              occluded_flag = 1; r.status = ST_OCCLUDED;
            end
          end
        end
        found_now = 0;
      end
      default: begin
        if (tracking_on) begin
          if (ok) begin
            roi = b; r.status = ST_UPDATED;
          end else begin
            tracking_on = 0; occluded_flag = 1; r.status = ST_LOST;
          end
        end
      end
    endcase
    r.roi = roi; r.trk = tracking_on; r.occ = occluded_flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one request and record its expected result
  task automatic send_request(req_e req, box_t b, logic ok);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({ok, b});
    s_axis_tuser  <= req;
    expected_q.insert(expected_q.size(), predict_association(req, b, ok));
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    // the block is busy for at least this cycle after a transaction
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [THR_W-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SELECT_IOU:   thr_select = val;
      CFG_ACCEPT_IOU:   thr_accept = val;
      CFG_DISTRACT_IOU: thr_distract = val;
      default:          area_tol = val;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    box_t got_roi;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        got_roi = m_axis_tdata[BOX_W-1:0];
        if (m_axis_tuser != want.status) report_mismatch("status", m_axis_tuser, want.status);
        if (got_roi.x != want.roi.x) report_mismatch("roi_x", got_roi.x, want.roi.x);
        if (got_roi.y != want.roi.y) report_mismatch("roi_y", got_roi.y, want.roi.y);
        if (got_roi.w != want.roi.w) report_mismatch("roi_w", got_roi.w, want.roi.w);
        if (got_roi.h != want.roi.h) report_mismatch("roi_h", got_roi.h, want.roi.h);
        if (m_axis_tdata[BOX_W] != want.reinit)
          report_mismatch("reinit", m_axis_tdata[BOX_W], want.reinit);
        if (m_axis_tdata[BOX_W+1] != want.trk)
          report_mismatch("tracking", m_axis_tdata[BOX_W+1], want.trk);
        if (m_axis_tdata[BOX_W+2] != want.occ)
          report_mismatch("occluded", m_axis_tdata[BOX_W+2], want.occ);
      end
    end
  end

  // receiver stalls in random bursts unless quiet
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_axis_tready <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      if (rx_stall == 0) m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall = $urandom_range(1, 6);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_track_box_association_memory: FAIL");
      $finish;
    end
  end

  function automatic box_t mk(int x, int y, int w, int h);
    box_t b;
    b.x = x; b.y = y; b.w = w; b.h = h;
    return b;
  endfunction

  function automatic box_t rand_box();
    return mk($urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 4095), $urandom_range(0, 4095));
  endfunction

  // box near a reference, jittered by up to the given spread
  function automatic box_t jitter(box_t r, int spread);
    box_t b;
    int v;
    v = int'(r.x) + $urandom_range(0, 2*spread) - spread; b.x = (v < 0) ? 0 : v;
    v = int'(r.y) + $urandom_range(0, 2*spread) - spread; b.y = (v < 0) ? 0 : v;
    v = int'(r.w) + $urandom_range(0, spread) - spread/2; b.w = (v < 1) ? 1 : v;
    v = int'(r.h) + $urandom_range(0, spread) - spread/2; b.h = (v < 1) ? 1 : v;
    return b;
  endfunction

  task automatic test_directed();
    send_request(REQ_DETECT, mk(0, 0, 10, 10), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_REPORT, mk(1, 1, 1, 1), 1'b1);
    send_request(REQ_SELECT, mk(100, 100, 0, 50), 1'b0);
    send_request(REQ_SELECT, mk(100, 100, 50, 50), 1'b0);
    send_request(REQ_DETECT, mk(2000, 2000, 50, 50), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_SELECT, mk(100, 100, 50, 50), 1'b0);
    send_request(REQ_SELECT, mk(102, 100, 50, 50), 1'b0);
    send_request(REQ_DETECT, mk(104, 101, 50, 50), 1'b0);
    send_request(REQ_DETECT, mk(104, 101, 50, 50), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_DETECT, mk(106, 102, 50, 50), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_DETECT, mk(900, 900, 52, 49), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_REPORT, mk(4095, 4095, 4095, 4095), 1'b1);
    send_request(REQ_DETECT, mk(4095, 4095, 4095, 4095), 1'b1);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_REPORT, mk(0, 0, 0, 0), 1'b0);
    send_request(REQ_END, '0, 1'b0);
    send_request(REQ_SELECT, mk(4095, 4095, 4095, 4095), 1'b1);
    send_request(REQ_END, '0, 1'b0);
  endtask

  // mostly well-formed frames around the tracked box, plus noise
  task automatic test_random_frames(int n_items);
    int sent, k, ndet;
    box_t base;
    sent = 0;
    while (sent < n_items) begin
      base = mk($urandom_range(0, 3000), $urandom_range(0, 3000),
                $urandom_range(1, 600), $urandom_range(1, 600));
      if ($urandom_range(0, 9) == 0) base = rand_box();
      send_request(REQ_SELECT, base, $urandom_range(0, 1)); sent++;
      repeat ($urandom_range(2, 8)) begin
        ndet = $urandom_range(0, 4);
        for (k = 0; k < ndet; k++) begin
          case ($urandom_range(0, 5))
            0, 1: send_request(REQ_DETECT, jitter(roi, 8), $urandom_range(0, 1));
            2, 3: send_request(REQ_DETECT,
                    mk($urandom_range(0, 3500), $urandom_range(0, 3500),
                       roi.w + $urandom_range(0, 8), roi.h), $urandom_range(0, 1));
            4: send_request(REQ_DETECT, jitter(roi, 60), 1'b0);
            default: send_request(req_e'($urandom_range(0, 3)), rand_box(), $urandom_range(0, 1));
          endcase
          sent++;
        end
        send_request(REQ_END, rand_box(), $urandom_range(0, 1)); sent++;
        if ($urandom_range(0, 2) == 0) begin
          send_request(REQ_REPORT, jitter(roi, 4), $urandom_range(0, 7) != 0); sent++;
        end
      end
    end
  endtask

  task automatic test_thresholds();
    wait_drained();
    write_reg(CFG_SELECT_IOU, 0);
    write_reg(CFG_ACCEPT_IOU, 256);
    write_reg(CFG_DISTRACT_IOU, 256);
    write_reg(CFG_AREA_TOL, 256);
    test_random_frames(300);
    wait_drained();
    write_reg(CFG_SELECT_IOU, 256);
    write_reg(CFG_ACCEPT_IOU, 0);
    write_reg(CFG_DISTRACT_IOU, 0);
    write_reg(CFG_AREA_TOL, 0);
    test_random_frames(250);
    wait_drained();
    write_reg(CFG_SELECT_IOU, $urandom_range(0, 511));
    write_reg(CFG_ACCEPT_IOU, $urandom_range(0, 511));
    write_reg(CFG_DISTRACT_IOU, $urandom_range(0, 511));
    write_reg(CFG_AREA_TOL, $urandom_range(0, 511));
    test_random_frames(250);
    wait_drained();
    write_reg(CFG_SELECT_IOU, 102);
    write_reg(CFG_ACCEPT_IOU, 102);
    write_reg(CFG_DISTRACT_IOU, 102);
    write_reg(CFG_AREA_TOL, 230);
  endtask

  initial begin
    predictor_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random_frames(550);
    test_thresholds();
    quiet = 1'b1;
    test_random_frames(380);
    wait_drained();
    if (errors == 0) begin
      $display("tb_track_box_association_memory: PASS");
    end else begin
      $display("tb_track_box_association_memory: FAIL");
    end
    $finish;
  end

endmodule
